// ===== hw/rtl/lwbc_pkg.sv =====
// shared types and constants for the lru write-back cache model
// no dependencies

package lwbc_pkg;

    localparam int WAYS        = 4;
    localparam int SETS        = 16;
    localparam int OFFSET_BITS = 5;
    localparam int ADDR_WIDTH  = 20;

    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AGE_W      = WAY_W;
    localparam int SET_W      = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int INDEX_BITS = $clog2(SETS + 1) - 1;
    localparam int TAG_W      = ADDR_WIDTH - OFFSET_BITS - INDEX_BITS;

    localparam int BITS_W     = 7;
    localparam int CYC_OUT_W  = 9;
    localparam int CYC_W      = 10;
    localparam int CNT_W      = 32;
    localparam int TIME_W     = 40;

    localparam logic [CYC_W-1:0] READ_HIT_BASE   = CYC_W'(7);
    localparam logic [CYC_W-1:0] WRITE_HIT_COST  = CYC_W'(8);
    localparam logic [CYC_W-1:0] READ_MISS_BASE  = CYC_W'(5);
    localparam logic [CYC_W-1:0] WRITE_MISS_BASE = CYC_W'(6);
    localparam logic [CYC_W-1:0] FILL_COST       = CYC_W'(101 + (2 ** OFFSET_BITS) / 2);
    localparam logic [CYC_W-1:0] WRITEBACK_COST  = CYC_W'(102);
    localparam logic [CYC_W-1:0] DATA_ROUND      = CYC_W'(15);
    localparam int               DATA_SHIFT      = 4;
    localparam logic [CYC_W-1:0] CYC_MAX         = CYC_W'(2 ** CYC_OUT_W - 1);

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             valid;
        logic             dirty;
        logic [AGE_W-1:0] age;
    } way_entry_t;

    typedef way_entry_t [WAYS-1:0] set_row_t;

    localparam int ROW_W = $bits(set_row_t);

    // summary of one finished access for the statistics unit
    typedef struct packed {
        logic              hit;
        logic              wb;
        logic              is_write;
        logic [BITS_W-1:0] bits;
    } acc_info_t;

endpackage

// ===== hw/rtl/lwbc_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies

module lwbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/lwbc_stats.sv =====
// access cost calculation and saturating hit, miss and time counters
// depends on lwbc_pkg

module lwbc_stats
    import lwbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 commit,
    input  acc_info_t            info,
    output logic [CYC_OUT_W-1:0] access_cycles,
    output logic [CNT_W-1:0]     hit_total,
    output logic [CNT_W-1:0]     miss_total,
    output logic [TIME_W-1:0]    time_total
);

    logic [CYC_OUT_W-1:0] cyc_reg, cyc_next;
    logic [CNT_W-1:0]     hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]     miss_cnt_reg, miss_cnt_next;
    logic [TIME_W-1:0]    time_reg, time_next;

    logic [CYC_W-1:0]     data_cyc;
    logic [CYC_W-1:0]     cyc_raw;
    logic [CYC_OUT_W-1:0] cyc_sat;
    logic [TIME_W:0]      time_sum;

    always_comb
    begin
        data_cyc = (CYC_W'(info.bits) + DATA_ROUND) >> DATA_SHIFT;
        if (info.hit)
        begin
            cyc_raw = (info.is_write == OP_WRITE) ? WRITE_HIT_COST : READ_HIT_BASE + data_cyc;
        end
        else
        begin
            cyc_raw = ((info.is_write == OP_WRITE) ? WRITE_MISS_BASE
                                                   : READ_MISS_BASE + data_cyc)
                      + FILL_COST + (info.wb ? WRITEBACK_COST : '0);
        end
        cyc_sat  = (cyc_raw > CYC_MAX) ? CYC_MAX[CYC_OUT_W-1:0] : cyc_raw[CYC_OUT_W-1:0];
        time_sum = {1'b0, time_reg} + (TIME_W + 1)'(cyc_sat);

        cyc_next      = cyc_reg;
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        time_next     = time_reg;
        if (commit)
        begin
            cyc_next  = cyc_sat;
            time_next = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
            if (info.hit)
            begin
                if (hit_cnt_reg != '1)
                begin
                    hit_cnt_next = hit_cnt_reg + 1'b1;
                end
            end
            else if (miss_cnt_reg != '1)
            begin
                miss_cnt_next = miss_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyc_reg      <= '0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            time_reg     <= '0;
        end
        else
        begin
            cyc_reg      <= cyc_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            time_reg     <= time_next;
        end
    end

    assign access_cycles = cyc_reg;
    assign hit_total     = hit_cnt_reg;
    assign miss_total    = miss_cnt_reg;
    assign time_total    = time_reg;

endmodule

// ===== hw/rtl/lru_write_back_cache_model.sv =====
// top level of the lru write-back cache model: sequencer, way scan and lru update
// depends on lwbc_pkg, lwbc_ram and lwbc_stats

// Each access passes through load, scan, update and done states: load reads
// the set row from the ram, scan steps the single tag comparator through the
// set a way at a time, update applies the lru update and writes the row back,
// and done commits the statistics and offers the result word once any earlier
// result has been taken. The block accepts no access while one is in flight;
// the result word sits in an output register, so a new access can start while
// a result still waits. Sets start cold after reset without any clearing pass.

module lru_write_back_cache_model
    import lwbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  operation,
    input  logic [ADDR_WIDTH-1:0] address,
    input  logic [BITS_W-1:0]     access_bits,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  hit,
    output logic                  wrote_back,
    output logic [1:0]            way_used,
    output logic [CYC_OUT_W-1:0]  access_cycles,
    output logic [CNT_W-1:0]      hit_total,
    output logic [CNT_W-1:0]      miss_total,
    output logic [TIME_W-1:0]     time_total
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic             op_reg, op_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic [SET_W-1:0] set_reg, set_next;
    logic [BITS_W-1:0] bits_reg, bits_next;
    set_row_t         row_reg, row_next;
    logic [WAY_W-1:0] way_cnt_reg, way_cnt_next;
    logic             hit_reg, hit_next;
    logic [WAY_W-1:0] hit_way_reg, hit_way_next;
    logic             vic_found_reg, vic_found_next;
    logic [WAY_W-1:0] vic_way_reg, vic_way_next;
    logic             wb_reg, wb_next;
    logic [SETS-1:0]  row_init_reg, row_init_next;
    logic             out_valid_reg, out_valid_next;
    logic             hit_out_reg, hit_out_next;
    logic             wb_out_reg, wb_out_next;
    logic [WAY_W-1:0] way_out_reg, way_out_next;

    logic                  accept;
    logic [ADDR_WIDTH-1:0] line_addr;
    logic [SET_W-1:0]      in_set;
    logic [TAG_W-1:0]      in_tag;
    set_row_t              ram_rdata;
    set_row_t              new_row;
    logic                  ram_we;
    way_entry_t            scan_entry;
    logic                  scan_match;
    logic                  scan_old;
    logic [WAY_W-1:0]      sel_way;
    logic [AGE_W-1:0]      sel_age;
    logic                  commit;
    acc_info_t             info;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign line_addr = address >> OFFSET_BITS;
    assign in_set    = SET_W'(line_addr % SETS);
    assign in_tag    = TAG_W'(address >> (OFFSET_BITS + INDEX_BITS));

    lwbc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (set_reg),
        .wdata (new_row),
        .re    (accept),
        .raddr (in_set),
        .rdata (ram_rdata)
    );

    // single shared tag and age comparator
    assign scan_entry = row_reg[way_cnt_reg];
    assign scan_match = scan_entry.valid && (scan_entry.tag == tag_reg);
    assign scan_old   = (scan_entry.age == AGE_W'(WAYS - 1));

    assign sel_way = hit_reg ? hit_way_reg : vic_way_reg;
    assign sel_age = row_reg[sel_way].age;

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            new_row[i] = row_reg[i];
            if (WAY_W'(i) == sel_way)
            begin
                new_row[i].age = '0;
                if (hit_reg)
                begin
                    new_row[i].dirty = row_reg[i].dirty || (op_reg == OP_WRITE);
                end
                else
                begin
                    new_row[i].tag   = tag_reg;
                    new_row[i].valid = 1'b1;
                    new_row[i].dirty = (op_reg == OP_WRITE);
                end
            end
            else if (row_reg[i].age < sel_age)
            begin
                new_row[i].age = row_reg[i].age + 1'b1;
            end
        end
    end

    assign info.hit      = hit_reg;
    assign info.wb       = wb_reg;
    assign info.is_write = op_reg;
    assign info.bits     = bits_reg;

    lwbc_stats u_stats (
        .clk           (clk),
        .rst_n         (rst_n),
        .commit        (commit),
        .info          (info),
        .access_cycles (access_cycles),
        .hit_total     (hit_total),
        .miss_total    (miss_total),
        .time_total    (time_total)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        tag_next       = tag_reg;
        set_next       = set_reg;
        bits_next      = bits_reg;
        row_next       = row_reg;
        way_cnt_next   = way_cnt_reg;
        hit_next       = hit_reg;
        hit_way_next   = hit_way_reg;
        vic_found_next = vic_found_reg;
        vic_way_next   = vic_way_reg;
        wb_next        = wb_reg;
        row_init_next  = row_init_reg;
        out_valid_next = out_valid_reg && !out_ready;
        hit_out_next   = hit_out_reg;
        wb_out_next    = wb_out_reg;
        way_out_next   = way_out_reg;
        ram_we         = 1'b0;
        commit         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = operation;
                    tag_next   = in_tag;
                    set_next   = in_set;
                    bits_next  = access_bits;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                // a cold set reads as empty with ages equal to way numbers
                if (row_init_reg[set_reg])
                begin
                    row_next = ram_rdata;
                end
                else
                begin
                    for (int i = 0; i < WAYS; i++)
                    begin
                        row_next[i].tag   = '0;
                        row_next[i].valid = 1'b0;
                        row_next[i].dirty = 1'b0;
                        row_next[i].age   = AGE_W'(i);
                    end
                end
                way_cnt_next   = '0;
                hit_next       = 1'b0;
                hit_way_next   = '0;
                vic_found_next = 1'b0;
                vic_way_next   = '0;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_match && !hit_reg)
                begin
                    hit_next     = 1'b1;
                    hit_way_next = way_cnt_reg;
                end
                if (scan_old && !vic_found_reg)
                begin
                    vic_found_next = 1'b1;
                    vic_way_next   = way_cnt_reg;
                end
                if (way_cnt_reg == WAY_W'(WAYS - 1))
                begin
                    state_next = S_UPDATE;
                end
                else
                begin
                    way_cnt_next = way_cnt_reg + 1'b1;
                end
            end
            S_UPDATE:
            begin
                ram_we                 = 1'b1;
                row_init_next[set_reg] = 1'b1;
                wb_next    = !hit_reg && row_reg[vic_way_reg].valid
                             && row_reg[vic_way_reg].dirty;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    commit         = 1'b1;
                    out_valid_next = 1'b1;
                    hit_out_next   = hit_reg;
                    wb_out_next    = wb_reg;
                    way_out_next   = sel_way;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_init_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_init_reg  <= row_init_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        tag_reg       <= tag_next;
        set_reg       <= set_next;
        bits_reg      <= bits_next;
        row_reg       <= row_next;
        way_cnt_reg   <= way_cnt_next;
        hit_reg       <= hit_next;
        hit_way_reg   <= hit_way_next;
        vic_found_reg <= vic_found_next;
        vic_way_reg   <= vic_way_next;
        wb_reg        <= wb_next;
        hit_out_reg   <= hit_out_next;
        wb_out_reg    <= wb_out_next;
        way_out_reg   <= way_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_out_reg;
    assign wrote_back = wb_out_reg;
    assign way_used   = 2'(way_out_reg);

`ifndef ASSERT_OFF
    a_no_wb_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && wrote_back))
        else $error("write-back reported on a hit");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("new access taken while one is in flight");

    a_victim_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE) && !hit_reg |-> vic_found_reg)
        else $error("miss without an oldest way");

    a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> time_total >= $past(time_total))
        else $error("time total decreased");
`endif

endmodule
